FILE: sv/srd_pkg.sv
`timescale 1ns / 1ps

package srd_pkg;

    // Control byte layout.
    localparam int unsigned TRANSP_BIT = 7;
    localparam int unsigned REPEAT_BIT = 6;

    localparam logic [7:0] TRANSPARENT_VALUE = 8'hFF;

    localparam logic [7:0] ROW_WIDTH_RESET    = 8'd32;
    localparam logic [7:0] FRAME_HEIGHT_RESET = 8'd32;

    // Register indexes on the configuration port.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic REG_ROW_WIDTH    = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        MODE_CTRL    = 2'd0,
        MODE_REPEAT  = 2'd1,
        MODE_LITERAL = 2'd2
    } mode_t;

    typedef struct packed {
        logic [7:0] row_width;
        logic [7:0] frame_height;
    } cfg_t;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic [6:0] run_length;
        logic [7:0] start_column;
        logic [7:0] row_index;
        logic       is_transparent;
        logic       row_end;
        logic       frame_end;
        logic       overrun;
    } result_t;

endpackage

FILE: sv/srd_cfg.sv
`timescale 1ns / 1ps

module srd_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output srd_pkg::cfg_t                 cfg
);
    import srd_pkg::*;

    logic [7:0] row_width_reg;
    logic [7:0] frame_height_reg;
    logic       reg_sel;
    logic       wr_en;

    // Register i sits at byte address 4*i.
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg    <= ROW_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_ROW_WIDTH:    row_width_reg    <= pwdata[7:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[7:0];
                default:          row_width_reg    <= row_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_ROW_WIDTH:    prdata = {24'd0, row_width_reg};
            REG_FRAME_HEIGHT: prdata = {24'd0, frame_height_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.row_width    = row_width_reg;
    assign cfg.frame_height = frame_height_reg;

endmodule

FILE: sv/srd_in_reg.sv
`timescale 1ns / 1ps

module srd_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] code_byte,
    input  logic       fire,
    output logic       held_valid,
    output logic [7:0] held_byte
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // The slot frees up in the same cycle its byte is decoded.
    assign in_ready = !valid_reg || fire;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (fire)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= code_byte;
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

FILE: sv/srd_core.sv
`timescale 1ns / 1ps

module srd_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       code_byte,
    input  srd_pkg::cfg_t    cfg,
    output logic             res_valid,
    output srd_pkg::result_t res
);
    import srd_pkg::*;

    mode_t      mode_reg, mode_next;
    logic [5:0] literal_left_reg, literal_left_next;
    logic [5:0] repeat_length_reg, repeat_length_next;
    logic [8:0] column_reg, column_next;
    logic [7:0] row_count_reg, row_count_next;

    logic       do_ctrl;
    logic       emit;
    logic       close_check;
    logic       transp;
    logic [7:0] value;
    logic [6:0] len;
    logic [9:0] col_sum;
    logic [8:0] col_wrap;
    logic       over;
    logic       rend;
    logic       fend;
    logic [7:0] row_plus;

    always_comb
    begin
        do_ctrl            = 1'b0;
        emit               = 1'b0;
        close_check        = 1'b0;
        transp             = 1'b0;
        value              = code_byte;
        len                = 7'd0;
        mode_next          = mode_reg;
        literal_left_next  = literal_left_reg;
        repeat_length_next = repeat_length_reg;

        unique case (mode_reg)
            MODE_REPEAT:
            begin
                // The value byte of a zero-length repeat is swallowed.
                mode_next = MODE_CTRL;
                if (repeat_length_reg != 6'd0)
                begin
                    emit        = 1'b1;
                    len         = {1'b0, repeat_length_reg};
                    close_check = 1'b1;
                end
            end
            MODE_LITERAL:
            begin
                if (literal_left_reg != 6'd0)
                begin
                    literal_left_next = literal_left_reg - 6'd1;
                    if (literal_left_reg == 6'd1)
                        mode_next = MODE_CTRL;
                    emit        = 1'b1;
                    len         = 7'd1;
                    // Only the last literal of a group may close the row.
                    close_check = (literal_left_reg == 6'd1);
                end
                else
                    do_ctrl = 1'b1;
            end
            default: do_ctrl = 1'b1;
        endcase

        if (do_ctrl)
        begin
            mode_next = MODE_CTRL;
            if (code_byte[TRANSP_BIT])
            begin
                len         = code_byte[6:0];
                emit        = (code_byte[6:0] != 7'd0);
                value       = TRANSPARENT_VALUE;
                transp      = 1'b1;
                close_check = 1'b1;
            end
            else if (code_byte[REPEAT_BIT])
            begin
                repeat_length_next = code_byte[5:0];
                mode_next          = MODE_REPEAT;
            end
            else
            begin
                literal_left_next = code_byte[5:0];
                if (code_byte[5:0] != 6'd0)
                    mode_next = MODE_LITERAL;
            end
        end
    end

    // Column and row bookkeeping for an emitted run.
    always_comb
    begin
        col_sum  = {1'b0, column_reg} + {3'd0, len};
        col_wrap = col_sum[8:0];
        over     = col_sum > {2'd0, cfg.row_width};
        rend     = close_check && (col_wrap >= {1'b0, cfg.row_width});
        row_plus = row_count_reg + 8'd1;
        fend     = rend && ((row_plus >= cfg.frame_height) || (row_plus == 8'd0));

        column_next    = column_reg;
        row_count_next = row_count_reg;
        if (emit)
        begin
            column_next = rend ? 9'd0 : col_wrap;
            if (rend)
                row_count_next = fend ? 8'd0 : row_plus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_CTRL;
            literal_left_reg  <= 6'd0;
            repeat_length_reg <= 6'd0;
            column_reg        <= 9'd0;
            row_count_reg     <= 8'd0;
        end
        else if (fire)
        begin
            mode_reg          <= mode_next;
            literal_left_reg  <= literal_left_next;
            repeat_length_reg <= repeat_length_next;
            column_reg        <= column_next;
            row_count_reg     <= row_count_next;
        end
    end

    assign res_valid          = emit;
    assign res.pixel_value    = value;
    assign res.run_length     = len;
    assign res.start_column   = column_reg[8] ? 8'hFF : column_reg[7:0];
    assign res.row_index      = row_count_reg;
    assign res.is_transparent = transp;
    assign res.row_end        = rend;
    assign res.frame_end      = fend;
    assign res.overrun        = over;

    a_literal_count: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_LITERAL |-> literal_left_reg != 6'd0)
        else $error("literal mode entered with no literal bytes left");

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> len != 7'd0)
        else $error("zero-length run emitted");

    a_frame_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        emit && fend |-> rend)
        else $error("frame end without row end");

    a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit && rend |=> column_reg == 9'd0)
        else $error("column not cleared after row end");

endmodule

FILE: sv/srd_out_reg.sv
`timescale 1ns / 1ps

module srd_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic             res_valid,
    input  srd_pkg::result_t res,
    input  logic             out_ready,
    output logic             out_valid,
    output srd_pkg::result_t out_res
);
    import srd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
            valid_next = res_valid;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

FILE: sv/sprite_rle_row_decoder.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    code_byte
// output    out        out_valid / out_ready  pixel_value, run_length, start_column,
//                                             row_index, is_transparent, row_end,
//                                             frame_end, overrun
// config    in/out     psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// One byte is accepted per cycle. It waits in the input register; its run descriptor is then
// loaded into the result register, from which its output transaction is made.
// A held byte is decoded whenever the result register is empty or being emptied, so a
// stalled output holds the decoder, and the input as well once the input register is full.
// Bytes that finish no run give no output transaction. Reset (rst_n low, asynchronous)
// empties both registers, starts row 0 awaiting a control byte, and loads width and height 32.
module sprite_rle_row_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    code_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    pixel_value,
    output logic [6:0]                    run_length,
    output logic [7:0]                    start_column,
    output logic [7:0]                    row_index,
    output logic                          is_transparent,
    output logic                          row_end,
    output logic                          frame_end,
    output logic                          overrun,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import srd_pkg::*;

    cfg_t       cfg;
    logic       held_valid;
    logic [7:0] held_byte;
    logic       fire;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    // A held byte is decoded when the result register can take its result.
    assign fire = held_valid && (!out_valid || out_ready);

    srd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .code_byte  (code_byte),
        .fire       (fire),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    srd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .code_byte (held_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    srd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign pixel_value    = out_res.pixel_value;
    assign run_length     = out_res.run_length;
    assign start_column   = out_res.start_column;
    assign row_index      = out_res.row_index;
    assign is_transparent = out_res.is_transparent;
    assign row_end        = out_res.row_end;
    assign frame_end      = out_res.frame_end;
    assign overrun        = out_res.overrun;

endmodule
